// ----- hw/rtl/dpcd_pkg.sv -----
// Shared types and constants of the delta patch command decoder.
`timescale 1ns / 1ps
`default_nettype none

package dpcd_pkg;

    // Integer coding: seven payload bits per byte, bit 7 marks continuation.
    localparam int GROUP_BITS = 7;
    localparam int CONT_BIT = 7;
    localparam int BYTE_W = 8;
    localparam int ACC_W = 64;
    localparam int WIDE_W = ACC_W + GROUP_BITS;
    localparam int MAX_INTEGER_BYTES_DEF = 10;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ADD_BASE    = 2'd0,
        CFG_SEQ_ADDS    = 2'd1,
        CFG_COPY_INDEX  = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FIELD_INDEX  = 2'd0,
        FIELD_OFFSET = 2'd1,
        FIELD_LENGTH = 2'd2
    } field_pos_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              start_of_stream;
    } in_beat_t;

    typedef struct packed {
        logic             is_add;
        logic [ACC_W-1:0] offset;
        logic [ACC_W-1:0] length;
        logic             overflow;
    } out_beat_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] add_base;
        logic                  sequential_adds;
        logic [CFG_DATA_W-1:0] copy_index;
    } cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/delta_patch_command_decoder_unit.sv -----
// Top level of the delta patch command decoder: config registers and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Datapath: each byte is held in the input register, and the decode logic then loads
// the result beat of its last byte into the result register.
// Throughput: one instruction byte per cycle while m_ready is high; the single result
// register, loaded from one pass of the decode logic, sets this rate.
// Reset: aresetn is synchronous and active low; it empties both register stages and
// clears the decode state and the configuration registers to zero.

module delta_patch_command_decoder_unit import dpcd_pkg::*; #(
    parameter int MAX_INTEGER_BYTES = MAX_INTEGER_BYTES_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire in_beat_t               s_payload,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output out_beat_t                   m_payload
);

    // Configuration registers. Writes are taken at any time; the user must only
    // write them while the decoder is idle, as the block has no interlock for it.
    cfg_t     cfg_reg, cfg_next;
    logic     in_valid;
    in_beat_t in_beat;
    logic     pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_ADD_BASE:   cfg_next.add_base        = cfg_data;
                CFG_SEQ_ADDS:   cfg_next.sequential_adds = cfg_data[0];
                CFG_COPY_INDEX: cfg_next.copy_index      = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // The input stage holds one byte beat; it is refilled in the cycle that
    // the decode stage consumes it, so bytes flow back to back.
    dpcd_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .pop       (pop),
        .valid     (in_valid),
        .beat      (in_beat)
    );

    // The decode stage folds each byte into the running integer and, on the
    // last byte of a length integer, loads a command into the result register.
    // It consumes a byte whenever the result register is empty or being taken.
    dpcd_decode #(
        .MAX_INTEGER_BYTES (MAX_INTEGER_BYTES)
    ) u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_beat   (in_beat),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/dpcd_in_reg.sv -----
// Input register stage holding one instruction byte beat.
`timescale 1ns / 1ps
`default_nettype none

module dpcd_in_reg import dpcd_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_beat_t s_payload,
    input  wire logic     pop,
    output logic          valid,
    output in_beat_t      beat
);

    logic     valid_reg, valid_next;
    in_beat_t beat_reg;

    // The stage refills in the same cycle that its beat moves on.
    assign s_ready = !valid_reg || pop;

    always_comb begin
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (pop) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            beat_reg <= s_payload;
        end
    end

    assign valid = valid_reg;
    assign beat  = beat_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/dpcd_decode.sv -----
// Integer accumulation, command assembly and result register.
`timescale 1ns / 1ps
`default_nettype none

module dpcd_decode import dpcd_pkg::*; #(
    parameter int MAX_INTEGER_BYTES = MAX_INTEGER_BYTES_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire cfg_t     cfg,
    input  wire logic     in_valid,
    input  wire in_beat_t in_beat,
    output logic          pop,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_beat_t     m_payload
);

    localparam int GC_W = $clog2(MAX_INTEGER_BYTES + 1);

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [GC_W-1:0]   gc_reg, gc_next;
    field_pos_t        field_reg, field_next;
    logic [ACC_W-1:0]  hidx_reg, hidx_next;
    logic [ACC_W-1:0]  hoff_reg, hoff_next;
    logic [ACC_W-1:0]  add_pos_reg, add_pos_next;
    logic              ovf_reg, ovf_next;
    logic              out_valid_reg, out_valid_next;
    out_beat_t         out_beat_reg, out_beat_next;

    logic              start;
    logic [GROUP_BITS-1:0] payload;
    logic [ACC_W-1:0]  acc0, acc1, acc_or;
    logic [GC_W-1:0]   gc0, gc1;
    field_pos_t        field0;
    logic [ACC_W-1:0]  hidx0, hoff0, add_pos0;
    logic              ovf0, ovf1, lost;
    logic [WIDE_W-1:0] wide;
    logic              emit;
    logic              is_copy;

    assign pop = in_valid && (!out_valid_reg || m_ready);

    always_comb begin
        start   = in_beat.start_of_stream;
        payload = in_beat.data_byte[GROUP_BITS-1:0];

        // A start beat clears the stream state, and reloads the add position from the base, before its byte is used.
        acc0     = start ? '0 : acc_reg;
        gc0      = start ? '0 : gc_reg;
        field0   = start ? FIELD_INDEX : field_reg;
        hidx0    = start ? '0 : hidx_reg;
        hoff0    = start ? '0 : hoff_reg;
        ovf0     = start ? 1'b0 : ovf_reg;
        add_pos0 = start ? ACC_W'(cfg.add_base) : add_pos_reg;

        // Place the group at its weight; bits above the accumulator are lost.
        acc_or = '0;
        lost   = 1'b0;
        wide   = '0;
        for (int g = 0; g < MAX_INTEGER_BYTES; g++) begin
            if (gc0 == GC_W'(g)) begin
                wide   = WIDE_W'(payload) << (GROUP_BITS * g);
                acc_or = wide[ACC_W-1:0];
                lost   = |wide[WIDE_W-1:ACC_W];
            end
        end
        if (gc0 >= GC_W'(MAX_INTEGER_BYTES)) begin
            lost = |payload;
            gc1  = gc0;
        end else begin
            gc1 = gc0 + GC_W'(1);
        end
        acc1 = acc0 | acc_or;
        ovf1 = ovf0 | lost;

        acc_next     = acc1;
        gc_next      = gc1;
        field_next   = field0;
        hidx_next    = hidx0;
        hoff_next    = hoff0;
        ovf_next     = ovf1;
        add_pos_next = add_pos0;
        emit         = 1'b0;
        is_copy      = (hidx0 == ACC_W'(cfg.copy_index));
        out_beat_next.is_add   = !is_copy;
        out_beat_next.offset   = hoff0;
        out_beat_next.length   = acc1;
        out_beat_next.overflow = ovf1;

        if (!in_beat.data_byte[CONT_BIT]) begin
            acc_next = '0;
            gc_next  = '0;
            unique case (field0)
                FIELD_OFFSET: begin
                    hoff_next  = acc1;
                    field_next = FIELD_LENGTH;
                end
                FIELD_LENGTH: begin
                    emit       = 1'b1;
                    field_next = FIELD_INDEX;
                    ovf_next   = 1'b0;
                    if (!is_copy) begin
                        if (cfg.sequential_adds) begin
                            out_beat_next.offset = hoff0 + add_pos0;
                            add_pos_next         = add_pos0 + acc1;
                        end else begin
                            out_beat_next.offset = hoff0 + ACC_W'(cfg.add_base);
                        end
                    end
                end
                default: begin
                    hidx_next  = acc1;
                    field_next = FIELD_OFFSET;
                end
            endcase
        end

        if (pop) begin
            out_valid_next = emit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            gc_reg        <= '0;
            field_reg     <= FIELD_INDEX;
            hidx_reg      <= '0;
            hoff_reg      <= '0;
            add_pos_reg   <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (pop) begin
                acc_reg     <= acc_next;
                gc_reg      <= gc_next;
                field_reg   <= field_next;
                hidx_reg    <= hidx_next;
                hoff_reg    <= hoff_next;
                add_pos_reg <= add_pos_next;
                ovf_reg     <= ovf_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && emit) begin
            out_beat_reg <= out_beat_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_beat_reg;

`ifndef SYNTH
    a_int_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !in_beat.data_byte[CONT_BIT] |=> gc_reg == '0 && acc_reg == '0)
        else $error("accumulator not cleared at end of integer");

    a_emit_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && emit |=> out_valid_reg && field_reg == FIELD_INDEX && !ovf_reg)
        else $error("command emission did not restart field sequence");

    a_fixed_base_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !cfg.sequential_adds && !in_beat.start_of_stream |=> $stable(add_pos_reg))
        else $error("add position moved with non-sequential adds");
`endif

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the delta patch command decoder top level.
`timescale 1ns / 1ps

module tb;
    import dpcd_pkg::*;

    localparam int MAX_BYTES    = MAX_INTEGER_BYTES_DEF;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BYTES  = 270;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_beat_t               s_payload = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_beat_t              m_payload;

    delta_patch_command_decoder_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #5 aclk = ~aclk;

    // Idling percentages for each side, and the long receiver stall.
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_go       = 1'b0;
    logic hold_off      = 1'b0;
    int   mismatches    = 0;

    // Our own view of the configuration registers, updated as each write lands.
    logic [31:0] cur_add_base   = '0;
    logic        cur_seq_adds   = 1'b0;
    logic [31:0] cur_copy_index = '0;

    // Decode state mirrored from the block.
    logic [63:0] acc_value    = '0;
    int unsigned groups_taken = 0;
    field_pos_t  field_pos    = FIELD_INDEX;
    logic [63:0] held_index   = '0;
    logic [63:0] held_offset  = '0;
    logic [63:0] add_position = '0;
    logic        ovf_seen     = 1'b0;

    in_beat_t  byte_queue[$];    // instruction bytes waiting to be offered
    out_beat_t cmd_expected[$];  // decoded commands not yet seen at the output
    logic      sos_next = 1'b0;  // flags the next byte queued as a stream start

    // Works out what one accepted instruction byte does to the decoder, and
    // queues the command it completes, if any.
    function automatic void decode_byte(in_beat_t b);
        logic [63:0]  value;
        out_beat_t    cmd;
        int unsigned  shift;
        if (b.start_of_stream) begin
            acc_value    = '0;
            groups_taken = 0;
            field_pos    = FIELD_INDEX;
            held_index   = '0;
            held_offset  = '0;
            ovf_seen     = 1'b0;
            add_position = {32'b0, cur_add_base};
        end
        // Payload beyond the byte limit, or landing above bit 63, is lost; losing
        // any set bit marks the command as overflowed.
        if (groups_taken >= MAX_BYTES) begin
            if (b.data_byte[GROUP_BITS-1:0] != 0)
                ovf_seen = 1'b1;
        end else begin
            shift = groups_taken * GROUP_BITS;
            if (shift < ACC_W) begin
                acc_value |= {57'b0, b.data_byte[GROUP_BITS-1:0]} << shift;
                if (shift > ACC_W - GROUP_BITS &&
                    (b.data_byte[GROUP_BITS-1:0] >> (ACC_W - shift)) != 0)
                    ovf_seen = 1'b1;
            end else if (b.data_byte[GROUP_BITS-1:0] != 0) begin
                ovf_seen = 1'b1;
            end
            groups_taken++;
        end
        if (b.data_byte[CONT_BIT])
            return;

        value        = acc_value;
        acc_value    = '0;
        groups_taken = 0;
        case (field_pos)
            FIELD_OFFSET: begin
                held_offset = value;
                field_pos   = FIELD_LENGTH;
            end
            FIELD_LENGTH: begin
                field_pos  = FIELD_INDEX;
                cmd.is_add = (held_index != {32'b0, cur_copy_index});
                if (!cmd.is_add) begin
                    cmd.offset = held_offset;
                end else if (cur_seq_adds) begin
                    cmd.offset   = held_offset + add_position;
                    add_position = add_position + value;
                end else begin
                    cmd.offset = held_offset + {32'b0, cur_add_base};
                end
                cmd.length   = value;
                cmd.overflow = ovf_seen;
                ovf_seen     = 1'b0;
                cmd_expected.push_back(cmd);
            end
            default: begin
                held_index = value;
                field_pos  = FIELD_OFFSET;
            end
        endcase
    endfunction

    function automatic void put_byte(logic [7:0] b);
        in_beat_t beat;
        beat.data_byte       = b;
        beat.start_of_stream = sos_next;
        sos_next             = 1'b0;
        byte_queue.push_back(beat);
    endfunction

    // Queues an integer as seven-bit groups, padded with zero groups up to nbytes.
    function automatic void put_int(logic [63:0] v, int nbytes);
        int          need = 1;
        logic [63:0] part;
        for (int i = 1; i < 10; i++)
            if ((v >> (GROUP_BITS * i)) != 0)
                need = i + 1;
        if (nbytes < need)
            nbytes = need;
        for (int i = 0; i < nbytes; i++) begin
            part = (i < 10) ? (v >> (GROUP_BITS * i)) : 64'd0;
            put_byte({i < nbytes - 1, part[GROUP_BITS-1:0]});
        end
    endfunction

    // A value of random bit length, so that short and full-width values both occur.
    function automatic logic [63:0] rand_val();
        int unsigned w = $urandom_range(0, 64);
        logic [63:0] v = {$urandom, $urandom};
        if (w < 64)
            v &= (64'd1 << w) - 64'd1;
        return v;
    endfunction

    // Mostly plain encodings, with some overlong ones and some random wide
    // integers that run past 64 bits or past the byte limit.
    function automatic void put_field(logic [63:0] v);
        int unsigned pick = $urandom_range(0, 99);
        int          n;
        if (pick < 6) begin
            n = $urandom_range(9, 12);
            for (int i = 0; i < n; i++)
                put_byte({i < n - 1, 7'($urandom)});
        end else if (pick < 14) begin
            put_int(v, $urandom_range(2, 12));
        end else begin
            put_int(v, 1);
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t ns: %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Writes one register and, once the write has been taken, our copy of it.
    task automatic write_reg(cfg_reg_t which, logic [31:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (which)
            CFG_ADD_BASE: cur_add_base   = value;
            CFG_SEQ_ADDS: cur_seq_adds   = value[0];
            default:      cur_copy_index = value;
        endcase
    endtask

    // Waits until every byte has gone in and every command has come out, then
    // allows for a trailing byte that completes no command.
    task automatic wait_drained();
        do @(negedge aclk);
        while (byte_queue.size() != 0 || s_valid || cmd_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_regs(logic [31:0] base, logic seq, logic [31:0] copy_idx);
        write_reg(CFG_ADD_BASE, base);
        write_reg(CFG_SEQ_ADDS, {31'b0, seq});
        write_reg(CFG_COPY_INDEX, copy_idx);
    endtask

    // One random phase: mainly well-formed commands with random content, plus
    // commands cut short by a new stream start and stray bytes.
    task automatic run_phase(int nbytes, logic with_hold);
        int unsigned pick;
        logic [63:0] index_val;
        @(negedge aclk);
        sos_next = 1'($urandom_range(0, 1));
        while (byte_queue.size() < nbytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                if ($urandom_range(0, 99) < 8)
                    sos_next = 1'b1;
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    index_val = {32'b0, cur_copy_index};
                else if (pick < 50)
                    index_val = {$urandom | 32'h1, cur_copy_index};
                else if (pick < 75)
                    index_val = 64'($urandom_range(0, 3));
                else
                    index_val = rand_val();
                put_field(index_val);
                put_field(rand_val());
                put_field(rand_val());
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 2)) put_field(rand_val());
                sos_next = 1'b1;
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    sos_next = ($urandom_range(0, 4) == 0);
                    put_byte(8'($urandom));
                end
            end
        end
        if (with_hold)
            hold_go <= 1'b1;
        wait_drained();
    endtask

    // Sender: offers queued bytes, sometimes idling, and feeds each accepted
    // beat to the predictor.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                decode_byte(s_payload);
            if (!s_valid || s_ready) begin
                if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_payload <= byte_queue.pop_front();
                    s_valid   <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result beat against the oldest decoded command.
    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (cmd_expected.size() == 0) begin
                    report_mismatch("result beat with no command pending", m_payload.offset, '0);
                end else begin
                    want = cmd_expected.pop_front();
                    if (m_payload.is_add !== want.is_add)
                        report_mismatch("is_add", 64'(m_payload.is_add), 64'(want.is_add));
                    if (m_payload.offset !== want.offset)
                        report_mismatch("offset", m_payload.offset, want.offset);
                    if (m_payload.length !== want.length)
                        report_mismatch("length", m_payload.length, want.length);
                    if (m_payload.overflow !== want.overflow)
                        report_mismatch("overflow", 64'(m_payload.overflow),
                                        64'(want.overflow));
                end
            end
            m_ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Long receiver stall while the sender keeps offering, so that the block backs up.
    initial begin : long_stall
        wait (hold_go);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin : stimulus
        repeat (4) @(posedge aclk);
        aresetn       <= 1'b1;
        send_idle_pct <= 27;
        recv_idle_pct <= 45;

        // Directed commands, with a base near the top of its range.
        set_regs(32'hFFFF_FFF0, 1'b1, 32'h0);
        @(negedge aclk);
        // No stream start yet: the running add position is still zero.
        put_int(64'd1, 1);
        put_int(64'd5, 1);
        put_int(64'd3, 1);
        // An offset of all ones written as eleven bytes: bits above 63 and a
        // byte past the limit are both lost, and the add offset wraps.
        put_int(64'd1, 1);
        repeat (9) put_byte(8'hFF);
        put_byte(8'h83);
        put_byte(8'h01);
        put_int(64'h7F, 1);
        // A fresh stream start in the middle of a command, then a copy.
        put_int(64'd9, 1);
        sos_next = 1'b1;
        put_int(64'd0, 1);
        put_int(64'h7F, 1);
        put_int(64'h80, 1);
        wait_drained();

        set_regs(32'h0, 1'b0, 32'h0);
        run_phase(PHASE_BYTES, 1'b0);
        set_regs(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        run_phase(PHASE_BYTES, 1'b0);

        @(negedge aclk);
        send_idle_pct <= 45;
        recv_idle_pct <= 27;
        set_regs($urandom, 1'b1, $urandom_range(0, 3));
        run_phase(PHASE_BYTES, 1'b0);
        set_regs($urandom, 1'b0, $urandom);
        run_phase(PHASE_BYTES, 1'b0);

        @(negedge aclk);
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        set_regs(32'hFFFF_FFFF, 1'b0, 32'h0);
        run_phase(PHASE_BYTES, 1'b1);
        set_regs($urandom, 1'b1, 32'd5);
        run_phase(PHASE_BYTES, 1'b0);

        if (mismatches == 0) begin
            $display("delta_patch_command_decoder_unit test passed");
        end else begin
            $display("delta_patch_command_decoder_unit test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("delta_patch_command_decoder_unit test failed");
        $finish;
    end

endmodule
